### hdl/vbad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbad_pkg
// Shared types and constants of the volume block average downsampler.
// ----------------------------------------------------------------------------
package vbad_pkg;

	localparam int DEF_MAX_OUT_W  = 256;
	localparam int DEF_MAX_OUT_H  = 256;
	localparam int DEF_MAX_FACTOR = 8;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int PADDR_W    = 5;

	typedef enum logic [2:0] {
		REG_SIZE_X   = 3'd0,
		REG_SIZE_Y   = 3'd1,
		REG_SIZE_Z   = 3'd2,
		REG_FACTOR_X = 3'd3,
		REG_FACTOR_Y = 3'd4,
		REG_FACTOR_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [3:0]  fx;
		logic [3:0]  fy;
		logic [3:0]  fz;
		logic [11:0] sx;
		logic [11:0] sy;
		logic [12:0] sz;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic               valid;
		logic               first;
		logic               last;
		logic [10:0]        ox;
		logic [10:0]        oy;
		logic [11:0]        oz;
	} vox_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_DONE
	} st_t;

endpackage
`default_nettype wire

### hdl/vbad_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbad_cfg
// Register file with clamping of sizes and factors to the supported grid.
// ----------------------------------------------------------------------------
module vbad_cfg #(
	parameter int MAX_OUT_W  = vbad_pkg::DEF_MAX_OUT_W,
	parameter int MAX_OUT_H  = vbad_pkg::DEF_MAX_OUT_H,
	parameter int MAX_FACTOR = vbad_pkg::DEF_MAX_FACTOR
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vbad_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              restart,
	output vbad_pkg::cfg_t                    cfg
);

	logic [11:0] size_x_q, size_y_q;
	logic [12:0] size_z_q;
	logic [3:0]  factor_x_q, factor_y_q, factor_z_q;
	logic        wr;
	logic [2:0]  ridx;
	logic [16:0] prod_x, prod_y, cap_x, cap_y;
	logic [12:0] sx_nz, sy_nz, sz_nz;

	assign wr   = psel && penable && pwrite;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   <= 12'd1;
			size_y_q   <= 12'd1;
			size_z_q   <= 13'd1;
			factor_x_q <= 4'd1;
			factor_y_q <= 4'd1;
			factor_z_q <= 4'd1;
		end else if (wr) begin
			unique case (ridx)
				vbad_pkg::REG_SIZE_X:   size_x_q   <= pwdata[11:0];
				vbad_pkg::REG_SIZE_Y:   size_y_q   <= pwdata[11:0];
				vbad_pkg::REG_SIZE_Z:   size_z_q   <= pwdata[12:0];
				vbad_pkg::REG_FACTOR_X: factor_x_q <= pwdata[3:0];
				vbad_pkg::REG_FACTOR_Y: factor_y_q <= pwdata[3:0];
				vbad_pkg::REG_FACTOR_Z: factor_z_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		restart = 1'b0;
		prdata  = 32'd0;
		unique case (ridx)
			vbad_pkg::REG_SIZE_X: begin
				restart = wr;
				prdata  = {20'd0, size_x_q};
			end
			vbad_pkg::REG_SIZE_Y: begin
				restart = wr;
				prdata  = {20'd0, size_y_q};
			end
			vbad_pkg::REG_SIZE_Z: begin
				restart = wr;
				prdata  = {19'd0, size_z_q};
			end
			vbad_pkg::REG_FACTOR_X: begin
				restart = wr;
				prdata  = {28'd0, factor_x_q};
			end
			vbad_pkg::REG_FACTOR_Y: begin
				restart = wr;
				prdata  = {28'd0, factor_y_q};
			end
			vbad_pkg::REG_FACTOR_Z: begin
				restart = wr;
				prdata  = {28'd0, factor_z_q};
			end
			default: ;
		endcase
	end

	function automatic logic [3:0] eff_factor(input logic [3:0] f);
		logic [3:0] r;
		r = f;
		if (f == 4'd0) r = 4'd1;
		else if (7'(f) > 7'(MAX_FACTOR)) r = 4'(MAX_FACTOR);
		return r;
	endfunction

	always_comb begin
		cfg.fx = eff_factor(factor_x_q);
		cfg.fy = eff_factor(factor_y_q);
		cfg.fz = eff_factor(factor_z_q);
		prod_x = 17'(MAX_OUT_W) * 17'(cfg.fx);
		prod_y = 17'(MAX_OUT_H) * 17'(cfg.fy);
		cap_x  = (prod_x > 17'd2048) ? 17'd2048 : prod_x;
		cap_y  = (prod_y > 17'd2048) ? 17'd2048 : prod_y;
		sx_nz  = (size_x_q == 12'd0) ? 13'd1 : {1'b0, size_x_q};
		sy_nz  = (size_y_q == 12'd0) ? 13'd1 : {1'b0, size_y_q};
		sz_nz  = (size_z_q == 13'd0) ? 13'd1 : size_z_q;
		cfg.sx = (17'(sx_nz) > cap_x) ? cap_x[11:0] : sx_nz[11:0];
		cfg.sy = (17'(sy_nz) > cap_y) ? cap_y[11:0] : sy_nz[11:0];
		cfg.sz = (sz_nz > 13'd4096) ? 13'd4096 : sz_nz;
	end

endmodule
`default_nettype wire

### hdl/vbad_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbad_front
// Tracks the raster position and tags each voxel with its block and edges.
// ----------------------------------------------------------------------------
module vbad_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  vbad_pkg::cfg_t      cfg,
	input  wire logic           restart,
	input  wire logic           in_fire,
	input  wire logic [15:0]    value,
	input  wire logic           valid,
	output vbad_pkg::vox_t      vox
);

	logic [10:0] px_q, py_q, ox_q, oy_q;
	logic [11:0] pz_q, oz_q;
	logic [3:0]  ibx_q, iby_q, ibz_q;
	logic        bx_end, by_end, bz_end, px_end, py_end, pz_end;

	assign bx_end = (5'(ibx_q) + 5'd1) >= 5'(cfg.fx);
	assign by_end = (5'(iby_q) + 5'd1) >= 5'(cfg.fy);
	assign bz_end = (5'(ibz_q) + 5'd1) >= 5'(cfg.fz);
	assign px_end = (12'(px_q) + 12'd1) >= cfg.sx;
	assign py_end = (12'(py_q) + 12'd1) >= cfg.sy;
	assign pz_end = (13'(pz_q) + 13'd1) >= cfg.sz;

	always_comb begin
		vox.value = value;
		vox.valid = valid;
		vox.first = (ibx_q == 4'd0) && (iby_q == 4'd0) && (ibz_q == 4'd0);
		vox.last  = (bx_end || px_end) && (by_end || py_end) && (bz_end || pz_end);
		vox.ox    = ox_q;
		vox.oy    = oy_q;
		vox.oz    = oz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q  <= '0; py_q  <= '0; pz_q  <= '0;
			ox_q  <= '0; oy_q  <= '0; oz_q  <= '0;
			ibx_q <= '0; iby_q <= '0; ibz_q <= '0;
		end else if (restart) begin
			px_q  <= '0; py_q  <= '0; pz_q  <= '0;
			ox_q  <= '0; oy_q  <= '0; oz_q  <= '0;
			ibx_q <= '0; iby_q <= '0; ibz_q <= '0;
		end else if (in_fire) begin
			if (!px_end) begin
				px_q  <= px_q + 11'd1;
				ibx_q <= bx_end ? 4'd0 : ibx_q + 4'd1;
				ox_q  <= bx_end ? ox_q + 11'd1 : ox_q;
			end else begin
				px_q  <= '0;
				ibx_q <= '0;
				ox_q  <= '0;
				if (!py_end) begin
					py_q  <= py_q + 11'd1;
					iby_q <= by_end ? 4'd0 : iby_q + 4'd1;
					oy_q  <= by_end ? oy_q + 11'd1 : oy_q;
				end else begin
					py_q  <= '0;
					iby_q <= '0;
					oy_q  <= '0;
					if (!pz_end) begin
						pz_q  <= pz_q + 12'd1;
						ibz_q <= bz_end ? 4'd0 : ibz_q + 4'd1;
						oz_q  <= bz_end ? oz_q + 12'd1 : oz_q;
					end else begin
						pz_q  <= '0;
						ibz_q <= '0;
						oz_q  <= '0;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### hdl/vbad_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbad_fifo
// Short queue of tagged voxels between the front and the back.
// ----------------------------------------------------------------------------
module vbad_fifo (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  vbad_pkg::vox_t wdata,
	output logic           full,
	input  wire logic      pop,
	output vbad_pkg::vox_t rdata,
	output logic           empty
);

	vbad_pkg::vox_t                  mem_q [vbad_pkg::FIFO_DEPTH];
	logic [vbad_pkg::FIFO_AW-1:0]    wptr_q, rptr_q;
	logic [vbad_pkg::FIFO_AW:0]      cnt_q;

	assign full  = cnt_q == (vbad_pkg::FIFO_AW+1)'(vbad_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (vbad_pkg::FIFO_AW+1)'(push) - (vbad_pkg::FIFO_AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

### hdl/vbad_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbad_back
// Accumulates voxels into per-block sums and divides finished blocks.
// ----------------------------------------------------------------------------
module vbad_back #(
	parameter int MAX_OUT_W  = vbad_pkg::DEF_MAX_OUT_W,
	parameter int MAX_OUT_H  = vbad_pkg::DEF_MAX_OUT_H,
	parameter int MAX_FACTOR = vbad_pkg::DEF_MAX_FACTOR
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  vbad_pkg::vox_t vox,
	input  wire logic      empty,
	output logic           pop,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	output logic [47:0]    m_tdata,
	output logic           m_tuser
);

	localparam int NBLK  = MAX_OUT_W * MAX_OUT_H;
	localparam int AW    = (NBLK > 1) ? $clog2(NBLK) : 1;
	localparam int NVOX  = MAX_FACTOR * MAX_FACTOR * MAX_FACTOR;
	localparam int CW    = $clog2(NVOX + 1);
	localparam int SW    = 17 + $clog2(NVOX + 1);
	localparam int DCW   = $clog2(SW + 1);

	logic [SW+CW-1:0]  mem [NBLK];
	logic [SW+CW-1:0]  rd_s;
	vbad_pkg::vox_t    item_q;
	vbad_pkg::st_t     st_q, st_d;
	logic [23:0]       idx_full, item_idx;
	logic [SW-1:0]     base_sum, new_sum, mag, quo_q;
	logic [CW-1:0]     base_cnt, new_cnt, cnt_q, rem_q;
	logic [CW:0]       rem_sh;
	logic              rem_ge, neg_q, mem_we, div_go, load_out, out_free;
	logic [DCW-1:0]    dcnt_q;
	logic [15:0]       avg;

	assign idx_full = 24'(vox.oy) * 24'(MAX_OUT_W) + 24'(vox.ox);
	assign item_idx = 24'(item_q.oy) * 24'(MAX_OUT_W) + 24'(item_q.ox);
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		base_sum = item_q.first ? '0 : rd_s[SW+CW-1:CW];
		base_cnt = item_q.first ? '0 : rd_s[CW-1:0];
		new_sum  = base_sum + (item_q.valid ? SW'(item_q.value) : '0);
		new_cnt  = base_cnt + CW'(item_q.valid);
		mag      = new_sum[SW-1] ? -new_sum : new_sum;
		rem_sh   = {rem_q, quo_q[SW-1]};
		rem_ge   = rem_sh >= {1'b0, cnt_q};
		avg      = neg_q ? 16'(-quo_q) : quo_q[15:0];
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			vbad_pkg::ST_IDLE: if (!empty) st_d = vbad_pkg::ST_READ;
			vbad_pkg::ST_READ: begin
				if (!item_q.last) st_d = vbad_pkg::ST_IDLE;
				else if (new_cnt == '0) st_d = vbad_pkg::ST_DONE;
				else st_d = vbad_pkg::ST_DIV;
			end
			vbad_pkg::ST_DIV: if (dcnt_q == DCW'(SW - 1)) st_d = vbad_pkg::ST_DONE;
			vbad_pkg::ST_DONE: if (out_free) st_d = vbad_pkg::ST_IDLE;
			default: st_d = vbad_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		mem_we   = 1'b0;
		div_go   = 1'b0;
		load_out = 1'b0;
		unique case (st_q)
			vbad_pkg::ST_IDLE: pop = !empty;
			vbad_pkg::ST_READ: mem_we = 1'b1;
			vbad_pkg::ST_DIV:  div_go = 1'b1;
			vbad_pkg::ST_DONE: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s   <= mem[idx_full[AW-1:0]];
			item_q <= vox;
		end
		if (mem_we) begin
			mem[item_idx[AW-1:0]] <= {new_sum, new_cnt};
			cnt_q  <= new_cnt;
			neg_q  <= new_sum[SW-1];
			quo_q  <= (new_cnt == '0) ? '0 : mag;
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (div_go) begin
			rem_q  <= rem_ge ? CW'(rem_sh - {1'b0, cnt_q}) : rem_sh[CW-1:0];
			quo_q  <= {quo_q[SW-2:0], rem_ge};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (load_out) begin
			m_tdata <= {4'd0, item_q.oz, item_q.oy[7:0], item_q.ox[7:0], avg};
			m_tuser <= cnt_q == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= vbad_pkg::ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_out) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### hdl/volume_block_average_downsampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// volume_block_average_downsampler
// Streaming 3D box-average downsampler with padding support.
// ----------------------------------------------------------------------------
// Voxels enter on the s_ channel in raster order, x fastest; s_tuser marks a
// present sample, padding beats add nothing. A result beat leaves on the m_
// channel when the last voxel of a block arrives, carrying the truncated mean
// and the block coordinates; m_tuser flags a block without present samples.
// Sizes and factors are set over the APB port; the user must write them only
// while the block is idle, which the block itself does not enforce. A write
// to any of the six registers restarts the volume at the origin; a write to
// an unknown address does not. A voxel that does not close a block passes
// the read-modify-write of the block memory. A voxel that closes a block
// with present samples then goes through the bit-serial divider, which
// works over the 27-bit sum width SW; a block of padding skips the divider.
// A four-deep queue lets the front take voxels while the back works.
// When the receiver stalls, one result waits in the output register and the
// back then stops, so the queue fills and s_tready falls. Reset clears the
// registers to 1 and the positions to 0; the block memory needs no clearing.
// ----------------------------------------------------------------------------
module volume_block_average_downsampler #(
	parameter int MAX_OUT_W  = vbad_pkg::DEF_MAX_OUT_W,
	parameter int MAX_OUT_H  = vbad_pkg::DEF_MAX_OUT_H,
	parameter int MAX_FACTOR = vbad_pkg::DEF_MAX_FACTOR
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [15:0]                  s_tdata,  // voxel_value
	input  wire logic                         s_tuser,  // voxel_valid
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [47:0]                       m_tdata,  // average, out_x, out_y, out_z
	output logic                              m_tuser,  // is_padding
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vbad_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	vbad_pkg::cfg_t cfg;
	vbad_pkg::vox_t vox_in, vox_out;
	logic           restart, full, empty, pop, in_fire;

	assign pready   = 1'b1;
	assign s_tready = !full;
	assign in_fire  = s_tvalid && !full;

	vbad_cfg #(
		.MAX_OUT_W (MAX_OUT_W),
		.MAX_OUT_H (MAX_OUT_H),
		.MAX_FACTOR(MAX_FACTOR)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.restart(restart),
		.cfg    (cfg)
	);

	vbad_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.restart(restart),
		.in_fire(in_fire),
		.value  (s_tdata),
		.valid  (s_tuser),
		.vox    (vox_in)
	);

	vbad_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (in_fire),
		.wdata (vox_in),
		.full  (full),
		.pop   (pop),
		.rdata (vox_out),
		.empty (empty)
	);

	vbad_back #(
		.MAX_OUT_W (MAX_OUT_W),
		.MAX_OUT_H (MAX_OUT_H),
		.MAX_FACTOR(MAX_FACTOR)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.vox     (vox_out),
		.empty   (empty),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the volume block average downsampler.
// ----------------------------------------------------------------------------
// Most random volumes add random voxel gaps and random receiver stalls.
// A model in the bench tracks the block sums, counts and raster position and
// predicts every result beat. Each received beat is compared field by field
// with the oldest prediction. Directed tests cover sample extremes, padding
// blocks, factor and size clamping, unknown registers and volume wrap.
// Random volumes with random settings follow.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE = 100;
	localparam int RANDOM_ITEMS = 230;

	typedef struct {
		logic signed [15:0] average;
		logic               is_padding;
		logic [7:0]         out_x;
		logic [7:0]         out_y;
		logic [11:0]        out_z;
	} block_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [15:0]                   s_tdata = '0;
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [47:0]                   m_tdata;  // average, out_x, out_y, out_z
	logic                          m_tuser;  // is_padding
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [vbad_pkg::PADDR_W-1:0]  paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	volume_block_average_downsampler dut (.*);

	always #1 clk = ~clk;

	localparam int MAX_BLOCKS = vbad_pkg::DEF_MAX_OUT_W * vbad_pkg::DEF_MAX_OUT_H;

	logic [11:0] reg_size_x, reg_size_y;
	logic [12:0] reg_size_z;
	logic [3:0]  reg_fx, reg_fy, reg_fz;
	int          block_sum [MAX_BLOCKS];
	int          block_cnt [MAX_BLOCKS];
	int          pos_x, pos_y, pos_z, off_x, off_y, off_z;

	block_result_t pending_blocks[$];
	int            errors = 0;
	int            cycles = 0;
	bit            idling = 1'b0;
	int            rx_wait = 0;

	function automatic int eff_factor(input logic [3:0] f);
		if (f == 0)
			return 1;
		if (f > vbad_pkg::DEF_MAX_FACTOR)
			return vbad_pkg::DEF_MAX_FACTOR;
		return f;
	endfunction

	function automatic int eff_size(input int s, input int cap);
		if (s == 0)
			s = 1;
		return (s > cap) ? cap : s;
	endfunction

	function automatic void restart_volume();
		pos_x = 0; pos_y = 0; pos_z = 0;
		off_x = 0; off_y = 0; off_z = 0;
	endfunction

	function automatic bit average_voxel(input logic signed [15:0] v, input logic present,
			output block_result_t r);
		int fx, fy, fz, sx, sy, sz, ox, oy, oz, idx, cap_x, cap_y;
		bit closes;
		fx = eff_factor(reg_fx);
		fy = eff_factor(reg_fy);
		fz = eff_factor(reg_fz);
		cap_x = vbad_pkg::DEF_MAX_OUT_W * fx;
		cap_y = vbad_pkg::DEF_MAX_OUT_H * fy;
		sx = eff_size(reg_size_x, (cap_x < 2048) ? cap_x : 2048);
		sy = eff_size(reg_size_y, (cap_y < 2048) ? cap_y : 2048);
		sz = eff_size(reg_size_z, 4096);
		ox = pos_x / fx;
		oy = pos_y / fy;
		oz = pos_z / fz;
		idx = (oy * vbad_pkg::DEF_MAX_OUT_W + ox) % MAX_BLOCKS;
		if (off_x == 0 && off_y == 0 && off_z == 0) begin
			block_sum[idx] = 0;
			block_cnt[idx] = 0;
		end
		if (present) begin
			block_sum[idx] += v;
			block_cnt[idx] += 1;
		end
		closes = (off_x + 1 >= fx || pos_x + 1 >= sx) && (off_y + 1 >= fy || pos_y + 1 >= sy)
			&& (off_z + 1 >= fz || pos_z + 1 >= sz);
		if (closes) begin
			r.average = (block_cnt[idx] != 0) ? 16'(block_sum[idx] / block_cnt[idx]) : '0;
			r.is_padding = (block_cnt[idx] == 0);
			r.out_x = 8'(ox);
			r.out_y = 8'(oy);
			r.out_z = 12'(oz);
		end
		pos_x++;
		off_x = (off_x + 1 >= fx) ? 0 : off_x + 1;
		if (pos_x >= sx) begin
			pos_x = 0; off_x = 0;
			pos_y++;
			off_y = (off_y + 1 >= fy) ? 0 : off_y + 1;
			if (pos_y >= sy) begin
				pos_y = 0; off_y = 0;
				pos_z++;
				off_z = (off_z + 1 >= fz) ? 0 : off_z + 1;
				if (pos_z >= sz) begin
					pos_z = 0; off_z = 0;
				end
			end
		end
		return closes;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		block_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_blocks.size() == 0) begin
					$error("unexpected result beat %h", m_tdata);
					errors++;
				end else begin
					want = pending_blocks.pop_front();
					if (m_tdata[15:0] !== want.average) begin
						$error("average: expected %0d, got %0d", want.average,
							$signed(m_tdata[15:0]));
						errors++;
					end
					if (m_tuser !== want.is_padding) begin
						$error("is_padding: expected %0d, got %0d", want.is_padding, m_tuser);
						errors++;
					end
					if (m_tdata[23:16] !== want.out_x) begin
						$error("out_x: expected %0d, got %0d", want.out_x, m_tdata[23:16]);
						errors++;
					end
					if (m_tdata[31:24] !== want.out_y) begin
						$error("out_y: expected %0d, got %0d", want.out_y, m_tdata[31:24]);
						errors++;
					end
					if (m_tdata[43:32] !== want.out_z) begin
						$error("out_z: expected %0d, got %0d", want.out_z, m_tdata[43:32]);
						errors++;
					end
				end
				rx_wait = idling ? $urandom_range(0, 17) : 0;
			end
			if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_voxel(input logic signed [15:0] v, input logic present);
		int gap;
		block_result_t r;
		gap = idling ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tuser <= present;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (average_voxel(v, present, r))
			pending_blocks.push_back(r);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input int index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= vbad_pkg::PADDR_W'(4 * index);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (index)
			vbad_pkg::REG_SIZE_X:   reg_size_x = value[11:0];
			vbad_pkg::REG_SIZE_Y:   reg_size_y = value[11:0];
			vbad_pkg::REG_SIZE_Z:   reg_size_z = value[12:0];
			vbad_pkg::REG_FACTOR_X: reg_fx = value[3:0];
			vbad_pkg::REG_FACTOR_Y: reg_fy = value[3:0];
			vbad_pkg::REG_FACTOR_Z: reg_fz = value[3:0];
			default:                return;
		endcase
		restart_volume();
	endtask

	task automatic set_volume(input int sx, sy, sz, fx, fy, fz);
		write_reg(vbad_pkg::REG_SIZE_X, sx);
		write_reg(vbad_pkg::REG_SIZE_Y, sy);
		write_reg(vbad_pkg::REG_SIZE_Z, sz);
		write_reg(vbad_pkg::REG_FACTOR_X, fx);
		write_reg(vbad_pkg::REG_FACTOR_Y, fy);
		write_reg(vbad_pkg::REG_FACTOR_Z, fz);
	endtask

	function automatic logic [15:0] random_sample();
		case ($urandom_range(0, 7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_voxel(16'sh7FFF, 1'b1);
		send_voxel(16'sh8000, 1'b1);
		send_voxel(16'sh0000, 1'b1);
		send_voxel(16'shFFFF, 1'b1);
		send_voxel(16'h5A5A, 1'b0);
		wait_idle();
	endtask

	task automatic test_partial_blocks();
		set_volume(3, 3, 2, 2, 2, 2);
		for (int i = 0; i < 18; i++)
			send_voxel(i[0] ? 16'sh8000 : 16'sh7FFF, i != 2 && i != 8);
		wait_idle();
	endtask

	task automatic test_factor_clamp();
		set_volume(3, 9, 1, 0, 15, 9);
		for (int i = 0; i < 27; i++)
			send_voxel(random_sample(), i % 5 != 0);
		wait_idle();
	endtask

	task automatic test_size_limits();
		idling = 1'b0;
		set_volume(0, 0, 0, 1, 1, 1);
		send_voxel(-16'sd7, 1'b1);
		wait_idle();
		set_volume(4095, 2, 1, 1, 1, 1);
		for (int i = 0; i < 260; i++)
			send_voxel(random_sample(), 1'b1);
		wait_idle();
		set_volume(1, 4095, 1, 1, 1, 1);
		for (int i = 0; i < 16; i++)
			send_voxel(random_sample(), 1'b1);
		wait_idle();
		set_volume(2048, 1, 1, 8, 1, 1);
		for (int i = 0; i < 64; i++)
			send_voxel(random_sample(), $urandom_range(0, 3) != 0);
		wait_idle();
		set_volume(1, 1, 8191, 1, 1, 1);
		for (int i = 0; i < 16; i++)
			send_voxel(random_sample(), 1'b1);
		wait_idle();
	endtask

	task automatic test_unknown_register();
		set_volume(2, 2, 2, 2, 2, 2);
		for (int i = 0; i < 3; i++)
			send_voxel(random_sample(), 1'b1);
		wait_idle();
		write_reg(6, 32'hFFFF_FFFF);
		write_reg(7, 32'h0000_0001);
		for (int i = 0; i < 13; i++)
			send_voxel(random_sample(), 1'b1);
		wait_idle();
	endtask

	task automatic test_random_volumes();
		int sent, voxels, empty_rate;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idling = $urandom_range(0, 3) != 0;
			set_volume($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) % 9 : $urandom_range(1, 6),
				$urandom_range(1, 6), $urandom_range(1, 5),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 4),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 4),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 4));
			voxels = eff_size(reg_size_x, 2048) * eff_size(reg_size_y, 2048)
				* eff_size(reg_size_z, 4096) * $urandom_range(1, 2);
			if ($urandom_range(0, 4) == 0)
				voxels = $urandom_range(1, voxels);
			if (voxels > RANDOM_ITEMS - sent)
				voxels = RANDOM_ITEMS - sent;
			empty_rate = $urandom_range(0, 3) == 0 ? 1 : 5;
			for (int i = 0; i < voxels; i++)
				send_voxel(random_sample(), $urandom_range(0, 5) < empty_rate);
			sent += voxels;
			wait_idle();
		end
	endtask

	initial begin
		reg_size_x = 1; reg_size_y = 1; reg_size_z = 1;
		reg_fx = 1; reg_fy = 1; reg_fz = 1;
		restart_volume();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_partial_blocks();
		test_factor_clamp();
		test_size_limits();
		test_unknown_register();
		test_random_volumes();
		if (errors == 0 && pending_blocks.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### volume_block_average_downsampler.f
hdl/vbad_pkg.sv
hdl/vbad_cfg.sv
hdl/vbad_front.sv
hdl/vbad_fifo.sv
hdl/vbad_back.sv
hdl/volume_block_average_downsampler.sv
tb/testbench.sv
